[sv/url_form_query_decoder_core_macros.svh]
`ifndef URL_FORM_QUERY_DECODER_CORE_MACROS_SVH
`define URL_FORM_QUERY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ufq_pkg.sv]
`default_nettype none

package ufq_pkg;

	// Most results one query byte can cause.
	localparam int RES_MAX     = 6;
	localparam int CNT_W       = $clog2(RES_MAX + 1);
	localparam int IDX_W       = $clog2(RES_MAX);
	localparam int TOKEN_LEN_W = 12;
	localparam int PAIR_IDX_W  = 9;

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HI_NIBBLE_MASK = 8'hf0;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_NAME   = 3'd1,
		KIND_VALUE  = 3'd2,
		KIND_PAIR   = 3'd3,
		KIND_STRING = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
	} query_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data_byte;
		logic [TOKEN_LEN_W-1:0] token_length;
		logic [PAIR_IDX_W-1:0]  pair_index;
		logic                   last;
	} result_t;

	// All results of one query byte, in order, and how many are valid.
	typedef struct packed {
		result_t [RES_MAX-1:0] items;
		logic [CNT_W-1:0]      count;
	} batch_t;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
			(c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= CH_0 && c <= CH_9) begin
			v = c - CH_0;
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = c - CH_UA + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

[sv/ufq_if.sv]
`default_nettype none

interface ufq_query_if import ufq_pkg::*; ();
	logic   valid;
	logic   ready;
	query_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ufq_result_if import ufq_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/ufq_decode.sv]
`default_nettype none

module ufq_decode import ufq_pkg::*; #(
	parameter int TOKEN_LEN_MAX = 4095,
	parameter int PAIR_MAX      = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] char_in,
	input  wire logic       is_last,
	output batch_t          batch
);

	localparam int TW = $clog2(TOKEN_LEN_MAX + 1);
	localparam int PW = $clog2(PAIR_MAX + 1);

	typedef struct packed {
		phase_t        phase;
		logic [7:0]    held;
		logic          vmode;
		logic [TW-1:0] tcnt;
		logic [PW-1:0] pcnt;
		logic          has_name;
	} st_t;

	typedef struct packed {
		st_t    s;
		batch_t b;
	} ctx_t;

	localparam st_t ST_RESET = '{
		phase:    PH_NONE,
		held:     8'h00,
		vmode:    1'b0,
		tcnt:     '0,
		pcnt:     '0,
		has_name: 1'b0
	};

	st_t  st_q;
	ctx_t nxt;

	function automatic ctx_t push(ctx_t x, kind_t k, logic [7:0] d, logic [TW-1:0] len);
		ctx_t y;
		y = x;
		if (y.b.count < CNT_W'(RES_MAX)) begin
			y.b.items[y.b.count[IDX_W-1:0]] = '{
				kind:         k,
				data_byte:    d,
				token_length: TOKEN_LEN_W'(len),
				pair_index:   PAIR_IDX_W'(y.s.pcnt),
				last:         1'b0
			};
			y.b.count = y.b.count + CNT_W'(1);
		end
		return y;
	endfunction

	function automatic ctx_t put_data(ctx_t x, logic [7:0] d);
		ctx_t y;
		y = push(x, KIND_DATA, d, '0);
		if (y.s.tcnt < TW'(TOKEN_LEN_MAX)) begin
			y.s.tcnt = y.s.tcnt + TW'(1);
		end
		return y;
	endfunction

	function automatic ctx_t close_pair(ctx_t x);
		ctx_t y;
		y = push(x, KIND_PAIR, 8'h00, '0);
		if (y.s.pcnt < PW'(PAIR_MAX)) begin
			y.s.pcnt = y.s.pcnt + PW'(1);
		end
		y.s.vmode    = 1'b0;
		y.s.tcnt     = '0;
		y.s.has_name = 1'b0;
		return y;
	endfunction

	function automatic ctx_t plain(ctx_t x, logic [7:0] c);
		ctx_t y;
		y = x;
		unique case (c)
			CH_PLUS: begin
				y = put_data(y, CH_SPACE);
			end
			CH_PCT: begin
				y.s.phase = PH_PCT;
			end
			CH_EQ: begin
				if (y.s.tcnt != '0) begin
					y = push(y, KIND_NAME, 8'h00, y.s.tcnt);
					y.s.has_name = 1'b1;
				end
				y.s.vmode = 1'b1;
				y.s.tcnt  = '0;
			end
			CH_AMP: begin
				if (y.s.vmode) begin
					y = push(y, KIND_VALUE, 8'h00, y.s.tcnt);
				end else if (y.s.tcnt != '0) begin
					y = push(y, KIND_NAME, 8'h00, y.s.tcnt);
				end
				y = close_pair(y);
			end
			default: begin
				y = put_data(y, c);
			end
		endcase
		return y;
	endfunction

	always_comb begin
		ctx_t             c;
		logic [IDX_W-1:0] last_idx;
		c.s = st_q;
		c.b = '0;
		c.s.phase = PH_NONE;
		unique case (st_q.phase)
			PH_PCT: begin
				if (is_hex(char_in)) begin
					c.s.held  = char_in;
					c.s.phase = PH_HEX;
				end else begin
					c = put_data(c, CH_PCT);
					c = plain(c, char_in);
				end
			end
			PH_HEX: begin
				if (is_hex(char_in)) begin
					c = put_data(c, ({hex_val(st_q.held), 4'h0} & HI_NIBBLE_MASK) |
						{4'h0, hex_val(char_in)});
				end else begin
					c = put_data(c, CH_PCT);
					c = put_data(c, st_q.held);
					c = plain(c, char_in);
				end
			end
			default: begin
				c = plain(c, char_in);
			end
		endcase

		if (is_last) begin
			if (c.s.phase == PH_PCT) begin
				c = put_data(c, CH_PCT);
			end else if (c.s.phase == PH_HEX) begin
				c = put_data(c, CH_PCT);
				c = put_data(c, c.s.held);
			end
			c.s.phase = PH_NONE;
			if (c.s.tcnt != '0) begin
				c = push(c, c.s.vmode ? KIND_VALUE : KIND_NAME, 8'h00, c.s.tcnt);
				c = close_pair(c);
			end else if (c.s.vmode && c.s.has_name) begin
				c = push(c, KIND_VALUE, 8'h00, '0);
				c = close_pair(c);
			end
			c = push(c, KIND_STRING, 8'h00, '0);
		end

		last_idx = IDX_W'(c.b.count - CNT_W'(1));
		if (c.b.count != '0) begin
			c.b.items[last_idx].last = 1'b1;
		end
		nxt = c;
	end

	assign batch = nxt.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (take) begin
			st_q <= is_last ? ST_RESET : nxt.s;
		end
	end

endmodule

`default_nettype wire

[sv/ufq_result_buf.sv]
`default_nettype none

module ufq_result_buf import ufq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire batch_t  batch,
	output logic         free,
	ufq_result_if.source result
);

	result_t [RES_MAX-1:0] items_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  drain_last;

	assign result.valid   = (cnt_q != '0);
	assign result.payload = items_q[idx_q];

	// The final entry leaving frees the buffer in the same cycle.
	assign drain_last = result.valid && result.ready && items_q[idx_q].last;
	assign free       = (cnt_q == '0) || drain_last;

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= batch.items;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
			idx_q <= '0;
		end else if (drain_last) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (result.valid && result.ready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

`default_nettype wire

[sv/url_form_query_decoder_core.sv]
// Streaming decoder for form-urlencoded query strings.
// The query channel carries one raw byte per transaction, with is_last set on
// the final byte of a string. The result channel carries decoded data bytes
// and token events (name end, value end, pair end, string end); the last flag
// marks the final result caused by one query byte.
// Results of a byte appear on the result channel in the cycle after the
// byte is accepted. The result buffer holds the results of one byte and hands
// out one per cycle while the receiver is ready; a byte that causes up to one
// result is taken every cycle while the receiver is ready.
// A new byte is accepted in the same cycle in which the last buffered result
// is taken, so the two channels overlap without a gap.
// When the receiver stalls, the buffered results stay on the port unchanged
// and the query channel stalls as soon as the buffer holds results.
// Reset clears the escape, token and pair state and empties the buffer. The
// final byte of a string also returns the decoder to that reset state.
`default_nettype none

module url_form_query_decoder_core import ufq_pkg::*; #(
	parameter int TOKEN_LEN_MAX = 4095,
	parameter int PAIR_MAX      = 256
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ufq_query_if.sink  query,
	ufq_result_if.source result
);

	logic   take;
	logic   buf_free;
	batch_t batch;

	// A query byte is taken whenever the result buffer is empty or drains now.
	assign query.ready = buf_free;
	assign take        = query.valid && buf_free;

	// Escape, token and pair state plus the single-pass decode of one byte.
	ufq_decode #(
		.TOKEN_LEN_MAX (TOKEN_LEN_MAX),
		.PAIR_MAX      (PAIR_MAX)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.char_in (query.payload.char_in),
		.is_last (query.payload.is_last),
		.batch   (batch)
	);

	// Registered results of the last byte, handed out one per cycle while the receiver is ready.
	ufq_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.batch  (batch),
		.free   (buf_free),
		.result (result)
	);

endmodule

`default_nettype wire

[sv/ufq_checker.sv]
`default_nettype none
`include "url_form_query_decoder_core_macros.svh"

module ufq_checker import ufq_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    res_valid,
	input wire logic    res_ready,
	input wire result_t res_payload
);

	`UFQ_ASSERT_NEXT(a_valid_held, clk, arst_n, res_valid && !res_ready, res_valid, "result valid dropped while stalled")
	`UFQ_ASSERT_NEXT(a_payload_held, clk, arst_n, res_valid && !res_ready, $stable(res_payload), "result payload changed while stalled")
	`UFQ_ASSERT_NOW(a_string_end_last, clk, arst_n, res_valid && res_payload.kind == KIND_STRING, res_payload.last, "string end is not the final result of its byte")
	`UFQ_ASSERT_NOW(a_data_no_length, clk, arst_n, res_valid && res_payload.kind == KIND_DATA, res_payload.token_length == '0, "data byte carries a token length")

endmodule

bind url_form_query_decoder_core ufq_checker u_ufq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);

`default_nettype wire

[dv/tb_url_form_query_decoder_core.sv]
`timescale 1ns / 1ps

// Testbench for the form-urlencoded query decoder.
// Query strings are pushed one byte per transaction on the query channel.
// A scoreboard object keeps its own copy of the escape, token and pair state.
// For every accepted query byte it works out the decoded results. Each
// accepted result transaction is checked against the oldest of those.
module tb_url_form_query_decoder_core import ufq_pkg::*; ();

	localparam int TOKEN_LEN_MAX = 4095;
	localparam int PAIR_MAX      = 256;
	localparam int RANDOM_ITEMS  = 240;

	// Decoding predictor and store of expected result transactions.
	class query_decode_scoreboard;
		result_t    expected_q[$];
		result_t    batch[$];
		int         errors;
		phase_t     esc;
		logic [7:0] held_ch;
		bit         in_value;
		bit         named;
		int         tok_len;
		int         pair_num;

		function new();
			errors   = 0;
			pair_num = 0;
			clear_state();
		endfunction

		function void clear_state();
			esc      = PH_NONE;
			held_ch  = 8'h00;
			in_value = 1'b0;
			named    = 1'b0;
			tok_len  = 0;
			pair_num = 0;
		endfunction

		function bit digit_ok(logic [7:0] c);
			return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
				(c >= CH_UA && c <= CH_UF);
		endfunction

		function logic [3:0] digit_value(logic [7:0] c);
			logic [7:0] d;
			d = 8'h00;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
			end
			return d[3:0];
		endfunction

		function void emit(kind_t k, logic [7:0] b, int len);
			result_t r;
			r.kind         = k;
			r.data_byte    = b;
			r.token_length = len[TOKEN_LEN_W-1:0];
			r.pair_index   = pair_num[PAIR_IDX_W-1:0];
			r.last         = 1'b0;
			batch.push_back(r);
		endfunction

		function void put_byte(logic [7:0] b);
			emit(KIND_DATA, b, 0);
			if (tok_len < TOKEN_LEN_MAX) begin
				tok_len++;
			end
		endfunction

		// The pair end carries the index of the pair being closed.
		function void end_pair();
			emit(KIND_PAIR, 8'h00, 0);
			if (pair_num < PAIR_MAX) begin
				pair_num++;
			end
			in_value = 1'b0;
			tok_len  = 0;
			named    = 1'b0;
		endfunction

		function void plain_char(logic [7:0] c);
			if (c == CH_PLUS) begin
				put_byte(CH_SPACE);
			end else if (c == CH_PCT) begin
				esc = PH_PCT;
			end else if (c == CH_EQ) begin
				if (tok_len > 0) begin
					emit(KIND_NAME, 8'h00, tok_len);
					named = 1'b1;
				end
				in_value = 1'b1;
				tok_len  = 0;
			end else if (c == CH_AMP) begin
				if (in_value) begin
					emit(KIND_VALUE, 8'h00, tok_len);
				end else if (tok_len > 0) begin
					emit(KIND_NAME, 8'h00, tok_len);
				end
				end_pair();
			end else begin
				put_byte(c);
			end
		endfunction

		function void note_query(query_t q);
			logic [7:0] c;
			c = q.char_in;
			batch.delete();
			case (esc)
				PH_PCT: begin
					if (digit_ok(c)) begin
						held_ch = c;
						esc     = PH_HEX;
					end else begin
						esc = PH_NONE;
						put_byte(CH_PCT);
						plain_char(c);
					end
				end
				PH_HEX: begin
					esc = PH_NONE;
					if (digit_ok(c)) begin
						put_byte({digit_value(held_ch), digit_value(c)});
					end else begin
						put_byte(CH_PCT);
						put_byte(held_ch);
						plain_char(c);
					end
				end
				default: begin
					esc = PH_NONE;
					plain_char(c);
				end
			endcase
			if (q.is_last) begin
				// A cut escape comes out literally before the flush.
				if (esc == PH_PCT) begin
					put_byte(CH_PCT);
				end else if (esc == PH_HEX) begin
					put_byte(CH_PCT);
					put_byte(held_ch);
				end
				esc = PH_NONE;
				if (tok_len > 0) begin
					emit(in_value ? KIND_VALUE : KIND_NAME, 8'h00, tok_len);
					end_pair();
				end else if (in_value && named) begin
					emit(KIND_VALUE, 8'h00, 0);
					end_pair();
				end
				emit(KIND_STRING, 8'h00, 0);
				clear_state();
			end
			if (batch.size() > 0) begin
				batch[batch.size() - 1].last = 1'b1;
			end
			foreach (batch[i]) begin
				expected_q.push_back(batch[i]);
			end
		endfunction

		function void check_field(string field, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
					$time, r.kind, r.data_byte);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			check_field("kind", e.kind, r.kind);
			check_field("data_byte", e.data_byte, r.data_byte);
			check_field("token_length", e.token_length, r.token_length);
			check_field("pair_index", e.pair_index, r.pair_index);
			check_field("last", e.last, r.last);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ufq_query_if  query_bus ();
	ufq_result_if result_bus ();

	query_decode_scoreboard sb = new();

	// Chance per cycle that the sender holds back and the receiver stalls.
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;

	string hex_chars = "0123456789abcdefABCDEF";

	url_form_query_decoder_core #(
		.TOKEN_LEN_MAX(TOKEN_LEN_MAX),
		.PAIR_MAX     (PAIR_MAX)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_bus),
		.result(result_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver decides once per cycle, at the falling edge, whether it
	// takes a result transaction in the next cycle.
	initial begin
		result_bus.ready = 1'b0;
	end

	always @(negedge clk) begin
		result_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Results are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			sb.check_result(result_bus.payload);
		end
	end

	// Drives one query byte. Called at a falling edge and returns at the
	// falling edge after the transaction, so valid stays high between
	// back-to-back bytes and is only ever assigned once per time step.
	task automatic send_query(input logic [7:0] c, input logic fin);
		query_t q;
		q.char_in = c;
		q.is_last = fin;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			query_bus.valid <= 1'b0;
			@(negedge clk);
		end
		query_bus.valid   <= 1'b1;
		query_bus.payload <= q;
		do begin
			@(posedge clk);
		end while (!query_bus.ready);
		sb.note_query(q);
		@(negedge clk);
	endtask

	// The final byte of every string carries is_last.
	task automatic send_string(input logic [7:0] s[$]);
		foreach (s[i]) begin
			send_query(s[i], i == s.size() - 1);
		end
	endtask

	function automatic void add_text(ref logic [7:0] s[$], input string t);
		for (int i = 0; i < t.len(); i++) begin
			s.push_back(t[i]);
		end
	endfunction

	function automatic logic [7:0] pick_hex();
		return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(0, 3))
			0: return CH_PCT;
			1: return CH_EQ;
			2: return CH_AMP;
			default: return CH_PLUS;
		endcase
	endfunction

	// One unit of token content: a plain character, a '+', a good escape,
	// a broken escape or an arbitrary byte that may well be a delimiter.
	function automatic void add_unit(ref logic [7:0] s[$]);
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			s.push_back(8'($urandom_range(8'h21, 8'h7e)));
		end else if (pick < 55) begin
			s.push_back(CH_PLUS);
		end else if (pick < 75) begin
			s.push_back(CH_PCT);
			s.push_back(pick_hex());
			s.push_back(pick_hex());
		end else if (pick < 85) begin
			s.push_back(CH_PCT);
			if ($urandom_range(0, 1)) begin
				s.push_back(pick_hex());
			end
			c = 8'($urandom_range(0, 255));
			s.push_back(c);
		end else begin
			s.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Mostly well-formed name=value pairs joined by '&', with empty tokens,
	// repeated '=' and trailing delimiters mixed in.
	function automatic void build_form_string(ref logic [7:0] s[$]);
		int pairs;
		pairs = $urandom_range(1, 4);
		for (int p = 0; p < pairs; p++) begin
			repeat ($urandom_range(0, 6)) add_unit(s);
			if ($urandom_range(0, 9) != 0) begin
				s.push_back(CH_EQ);
				repeat ($urandom_range(0, 6)) add_unit(s);
				if ($urandom_range(0, 9) == 0) begin
					s.push_back(CH_EQ);
					repeat ($urandom_range(0, 3)) add_unit(s);
				end
			end
			if (p < pairs - 1 || $urandom_range(0, 4) == 0) begin
				s.push_back(CH_AMP);
			end
		end
		if (s.size() == 0) begin
			s.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Short strings of arbitrary bytes, heavy on delimiters.
	function automatic void build_noise_string(ref logic [7:0] s[$]);
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 1)) begin
				s.push_back(pick_delim());
			end else begin
				s.push_back(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic run_random(input int target);
		logic [7:0] s[$];
		int sent;
		sent = 0;
		while (sent < target) begin
			s.delete();
			if ($urandom_range(0, 4) == 0) begin
				build_noise_string(s);
			end else begin
				build_form_string(s);
			end
			send_string(s);
			sent += s.size();
		end
	endtask

	initial begin
		logic [7:0] s[$];
		arst_n            = 1'b0;
		query_bus.valid   = 1'b0;
		query_bus.payload = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed strings. The first one covers zero and all-ones raw bytes,
		// a good escape, '+', a name end, a second '=' that names the pair
		// again, a broken escape with a held digit ended by '&', an empty
		// token at '=', a broken escape without a digit, and an escape cut by
		// the end of the string while a digit is held.
		s = {8'h00, 8'hff};
		add_text(s, "%41+=v=%4&=%z&k=%A");
		send_string(s);
		// A name with an empty value at the end of the string.
		s.delete();
		add_text(s, "q=");
		send_string(s);
		// A lone '%' cut by the end of the string.
		s.delete();
		s.push_back(CH_PCT);
		send_string(s);
		// An empty pair closed by '&' on the final byte.
		s.delete();
		s.push_back(CH_AMP);
		send_string(s);

		// Random strings: slow receiver, then slow sender, then full rate.
		src_idle_pct  = 9;
		snk_stall_pct = 87;
		run_random(RANDOM_ITEMS / 3);
		src_idle_pct  = 87;
		snk_stall_pct = 9;
		run_random(RANDOM_ITEMS / 3);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		run_random(RANDOM_ITEMS / 3);

		// Saturation of the pair counter: a long run of empty pairs.
		s.delete();
		repeat (PAIR_MAX + 4) s.push_back(CH_AMP);
		add_text(s, "x=y");
		send_string(s);
		query_bus.valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("url_form_query_decoder_core regression: pass");
		end else begin
			$display("url_form_query_decoder_core regression: fail");
		end
		$finish;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("url_form_query_decoder_core regression: fail");
		$finish;
	end

endmodule

[url_form_query_decoder_core.f]
+incdir+sv
sv/ufq_pkg.sv
sv/ufq_if.sv
sv/ufq_decode.sv
sv/ufq_result_buf.sv
sv/url_form_query_decoder_core.sv
sv/ufq_checker.sv
dv/tb_url_form_query_decoder_core.sv
